/* src/lpg_pkg.sv */
`default_nettype none

package lpg_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int POS_W       = 4;
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_CHAR  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DONE  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_STATUS,
        S_SORT_RD,
        S_SORT_LOAD,
        S_SORT_SCAN,
        S_SORT_WR_A,
        S_SORT_WR_M,
        S_ADV_LOAD,
        S_ADV_SCAN,
        S_FIND_Q,
        S_SWAP_P,
        S_SWAP_Q,
        S_REV_CHK,
        S_REV_LO,
        S_REV_HI,
        S_REV_WR,
        S_EMIT_RD,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* src/lpg_in_if.sv */
`default_nettype none

interface lpg_in_if import lpg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CHAR_W-1:0] char_value;
    logic              start_string;

    modport source (output valid, output operation, output char_value, output start_string,
                    input ready);
    modport sink   (input valid, input operation, input char_value, input start_string,
                    output ready);
endinterface

`default_nettype wire

/* src/lpg_out_if.sv */
`default_nettype none

interface lpg_out_if import lpg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    position;
    logic [CHAR_W-1:0]   char_out;
    logic                last;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output position, output char_out, output last,
                    output status, input ready);
    modport sink   (input valid, input position, input char_out, input last,
                    input status, output ready);
endinterface

`default_nettype wire

/* src/lexicographic_permutation_generator_unit.sv */
// Load: no result. Already exhausted or empty request: a status result via S_STATUS.
// First request on a string: selection sort in the store, then one character per cycle
// while the receiver takes them. Later requests: pivot scan (done status if none), successor
// scan, swap and reversal through the single-port store, then characters at the same rate.
// One item is worked on at a time; the output register lets the next item in early.
// Synchronous active-low reset clears length, run flags, sequencer and output valid only.
`default_nettype none

module lexicographic_permutation_generator_unit import lpg_pkg::*; #(
    parameter int MAX_LEN = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpg_in_if.sink     i_in,
    lpg_out_if.source  o_out
);

    localparam int CAP    = (MAX_LEN < STORE_DEPTH) ? MAX_LEN : STORE_DEPTH;
    localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int LEN_W  = $clog2(CAP + 1);
    localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAP);

    logic [CHAR_W-1:0] r_store [CAP];
    logic [CHAR_W-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_first, n_first;
    logic              r_fin, n_fin;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_j, n_j;
    logic [ADDR_W-1:0] r_mi, n_mi;
    logic [CHAR_W-1:0] r_v0, n_v0;
    logic [CHAR_W-1:0] r_v1, n_v1;
    t_status           r_code, n_code;

    logic                r_ov;
    logic [POS_W-1:0]    r_pos;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;
    logic [STATUS_W-1:0] r_status;

    logic                rd_en, wr_en;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic [CHAR_W-1:0]   wr_data;
    logic                out_load;
    logic [POS_W-1:0]    out_pos;
    logic [CHAR_W-1:0]   out_char;
    logic                out_last;
    logic [STATUS_W-1:0] out_status;

    logic              in_fire;
    logic              out_free;
    logic [LEN_W-1:0]  load_base;
    logic              load_fits;
    logic [LEN_W-1:0]  len_m1;
    logic [ADDR_W-1:0] last_idx;
    logic [ADDR_W-1:0] i_inc, i_dec, j_inc, j_dec;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_ov || o_out.ready;
    assign load_base = i_in.start_string ? '0 : r_len;
    assign load_fits = load_base < CAP_L;
    assign len_m1    = r_len - LEN_W'(1);
    assign last_idx  = len_m1[ADDR_W-1:0];
    assign i_inc     = r_i + ADDR_W'(1);
    assign i_dec     = r_i - ADDR_W'(1);
    assign j_inc     = r_j + ADDR_W'(1);
    assign j_dec     = r_j - ADDR_W'(1);

    // next state and working registers
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_first = r_first;
        n_fin   = r_fin;
        n_i     = r_i;
        n_j     = r_j;
        n_mi    = r_mi;
        n_v0    = r_v0;
        n_v1    = r_v1;
        n_code  = r_code;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.operation == OP_LOAD) begin
                        n_len   = load_fits ? (load_base + LEN_W'(1)) : load_base;
                        n_first = 1'b0;
                        n_fin   = 1'b0;
                    end else if (r_len == '0) begin
                        n_code  = ST_EMPTY;
                        n_state = S_STATUS;
                    end else if (!r_first) begin
                        n_first = 1'b1;
                        n_i     = '0;
                        n_state = (r_len == LEN_W'(1)) ? S_EMIT : S_SORT_LOAD;
                    end else if (r_fin || r_len == LEN_W'(1)) begin
                        n_fin   = 1'b1;
                        n_code  = ST_DONE;
                        n_state = S_STATUS;
                    end else begin
                        n_state = S_ADV_LOAD;
                    end
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SORT_RD: begin
                n_state = S_SORT_LOAD;
            end
            S_SORT_LOAD: begin
                n_v0    = r_rdata;
                n_v1    = r_rdata;
                n_mi    = r_i;
                n_j     = i_inc;
                n_state = S_SORT_SCAN;
            end
            S_SORT_SCAN: begin
                if (r_rdata < r_v1) begin
                    n_v1 = r_rdata;
                    n_mi = r_j;
                end
                if (r_j == last_idx) begin
                    n_state = S_SORT_WR_A;
                end else begin
                    n_j = j_inc;
                end
            end
            S_SORT_WR_A: begin
                n_state = S_SORT_WR_M;
            end
            S_SORT_WR_M: begin
                if (i_inc == last_idx) begin
                    n_i     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_i     = i_inc;
                    n_state = S_SORT_RD;
                end
            end
            S_ADV_LOAD: begin
                n_v0    = r_rdata;
                n_i     = last_idx - ADDR_W'(1);
                n_state = S_ADV_SCAN;
            end
            S_ADV_SCAN: begin
                if (r_rdata < r_v0) begin
                    n_v0    = r_rdata;
                    n_j     = last_idx;
                    n_state = S_FIND_Q;
                end else if (r_i == '0) begin
                    n_fin   = 1'b1;
                    n_code  = ST_DONE;
                    n_state = S_STATUS;
                end else begin
                    n_v0 = r_rdata;
                    n_i  = i_dec;
                end
            end
            S_FIND_Q: begin
                if (r_rdata > r_v0) begin
                    n_v1    = r_rdata;
                    n_state = S_SWAP_P;
                end else begin
                    n_j = j_dec;
                end
            end
            S_SWAP_P: begin
                n_state = S_SWAP_Q;
            end
            S_SWAP_Q: begin
                n_i     = i_inc;
                n_j     = last_idx;
                n_state = S_REV_CHK;
            end
            S_REV_CHK: begin
                if (r_i < r_j) begin
                    n_state = S_REV_LO;
                end else begin
                    n_i     = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_REV_LO: begin
                n_v0    = r_rdata;
                n_state = S_REV_HI;
            end
            S_REV_HI: begin
                n_state = S_REV_WR;
            end
            S_REV_WR: begin
                n_i     = i_inc;
                n_j     = j_dec;
                n_state = S_REV_CHK;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_i == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = i_inc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // store accesses, input ready and result loading
    always_comb begin
        i_in.ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_i;
        wr_en      = 1'b0;
        wr_addr    = r_i;
        wr_data    = r_v0;
        out_load   = 1'b0;
        out_pos    = '0;
        out_char   = '0;
        out_last   = 1'b1;
        out_status = r_code;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.operation == OP_LOAD) begin
                        wr_en   = load_fits;
                        wr_addr = load_base[ADDR_W-1:0];
                        wr_data = i_in.char_value;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_first ? last_idx : '0;
                    end
                end
            end
            S_STATUS: begin
                out_load = out_free;
            end
            S_SORT_RD, S_REV_CHK, S_EMIT_RD: begin
                rd_en = 1'b1;
            end
            S_SORT_LOAD: begin
                rd_en   = 1'b1;
                rd_addr = i_inc;
            end
            S_SORT_SCAN: begin
                rd_en   = (r_j != last_idx);
                rd_addr = j_inc;
            end
            S_SORT_WR_A: begin
                wr_en   = 1'b1;
                wr_data = r_v1;
            end
            S_SORT_WR_M: begin
                wr_en   = 1'b1;
                wr_addr = r_mi;
            end
            S_ADV_LOAD: begin
                rd_en   = 1'b1;
                rd_addr = last_idx - ADDR_W'(1);
            end
            S_ADV_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = (r_rdata < r_v0) ? last_idx : i_dec;
            end
            S_FIND_Q: begin
                rd_en   = 1'b1;
                rd_addr = j_dec;
            end
            S_SWAP_P: begin
                wr_en   = 1'b1;
                wr_data = r_v1;
            end
            S_SWAP_Q, S_REV_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
            end
            S_REV_LO: begin
                rd_en   = 1'b1;
                rd_addr = r_j;
            end
            S_REV_HI: begin
                wr_en   = 1'b1;
                wr_data = r_rdata;
            end
            S_EMIT: begin
                out_load   = out_free;
                out_pos    = POS_W'(r_i);
                out_char   = r_rdata;
                out_last   = (r_i == last_idx);
                out_status = ST_CHAR;
                rd_en      = out_free && (r_i != last_idx);
                rd_addr    = i_inc;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_first <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_first <= n_first;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_mi   <= n_mi;
        r_v0   <= n_v0;
        r_v1   <= n_v1;
        r_code <= n_code;
    end

    // result register: a new result may replace one being transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_pos    <= out_pos;
            r_char   <= out_char;
            r_last   <= out_last;
            r_status <= out_status;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.position = r_pos;
    assign o_out.char_out = r_char;
    assign o_out.last     = r_last;
    assign o_out.status   = r_status;

endmodule

`default_nettype wire

/* src/lpg_checker.sv */
`default_nettype none

module lpg_checker import lpg_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_in_operation,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [POS_W-1:0]    i_out_position,
    input wire logic [CHAR_W-1:0]   i_out_char,
    input wire logic                i_out_last,
    input wire logic [STATUS_W-1:0] i_out_status
);

    // status results stand alone and carry no character
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != ST_CHAR)
        |-> (i_out_last && i_out_position == '0 && i_out_char == '0))
        else $error("status result not a lone last result");

    // a request always leaves input ready low in the cycle after its transfer
    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_operation == OP_NEXT) |=> !i_in_ready)
        else $error("input ready right after a request transfer");

    // no new item while a permutation is only partly out
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == ST_CHAR && !i_out_last) |-> !i_in_ready)
        else $error("input ready in the middle of a permutation");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_out_position) && $stable(i_out_char)
             && $stable(i_out_last) && $stable(i_out_status)))
        else $error("stalled result changed");

endmodule

bind lexicographic_permutation_generator_unit lpg_checker u_lpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_position (o_out.position),
    .i_out_char     (o_out.char_out),
    .i_out_last     (o_out.last),
    .i_out_status   (o_out.status)
);

`default_nettype wire

/* test/tb_top.sv */
module tb_top;
    import lpg_pkg::*;

    localparam int TB_MAX_LEN  = 16;
    localparam int CAPACITY    = (TB_MAX_LEN < STORE_DEPTH) ? TB_MAX_LEN : STORE_DEPTH;
    localparam int N_ITEMS     = 280;
    localparam int QUIET_ITEMS = 40;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 300;
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_DIRECTED  = 23;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] char_out;
        logic              last;
        t_status           status;
    } t_perm_result;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] ch;
        logic              st;
        logic              typed;
        t_status           want;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lpg_in_if  in_bus ();
    lpg_out_if out_bus ();

    lexicographic_permutation_generator_unit #(
        .MAX_LEN (TB_MAX_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #4 i_clk = ~i_clk;

    t_perm_result      perm_exp_q [$];
    t_perm_result      fresh_q [$];
    t_perm_result      mon_want;
    logic [CHAR_W-1:0] pm_store [STORE_DEPTH];
    int                pm_len       = 0;
    bit                pm_sorted    = 1'b0;
    bit                pm_exhausted = 1'b0;

    int mismatches    = 0;
    int cycle_cnt     = 0;
    int items_sent    = 0;
    int stall_left    = 0;
    bit gaps_on       = 1'b1;
    bit stalls_on     = 1'b1;
    bit long_hold_req = 1'b0;

    // typed rows: status-only results that follow directly from the state
    t_stim_row dir_tab [N_DIRECTED] = '{
        '{OP_NEXT, 8'h00, 1'b0, 1'b1, ST_EMPTY},  // request straight after reset
        '{OP_NEXT, 8'hA5, 1'b1, 1'b1, ST_EMPTY},  // payload ignored on request
        '{OP_LOAD, 8'hFF, 1'b1, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b1, ST_DONE},   // single char has no successor
        '{OP_NEXT, 8'h5A, 1'b1, 1'b1, ST_DONE},   // stays exhausted
        '{OP_LOAD, 8'h01, 1'b1, 1'b0, ST_CHAR},
        '{OP_LOAD, 8'h00, 1'b0, 1'b0, ST_CHAR},   // zero byte stored as data
        '{OP_LOAD, 8'h80, 1'b0, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},   // sort and emit
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},   // fully descending
        '{OP_NEXT, 8'h00, 1'b0, 1'b1, ST_DONE},
        '{OP_LOAD, 8'h41, 1'b1, 1'b0, ST_CHAR},
        '{OP_LOAD, 8'h41, 1'b0, 1'b0, ST_CHAR},   // duplicates
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b1, ST_DONE},
        '{OP_LOAD, 8'h7F, 1'b0, 1'b0, ST_CHAR},   // append restarts the run
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR},
        '{OP_NEXT, 8'h00, 1'b0, 1'b0, ST_CHAR}
    };

    function automatic void note_status(input t_status code);
        fresh_q.push_back('{position: '0, char_out: '0, last: 1'b1, status: code});
    endfunction

    function automatic void emit_store();
        for (int k = 0; k < pm_len; k++) begin
            fresh_q.push_back('{position: POS_W'(k), char_out: pm_store[k],
                                last: (k == pm_len - 1), status: ST_CHAR});
        end
    endfunction

    function automatic void predict_item(input logic op, input logic [CHAR_W-1:0] ch,
                                         input logic st);
        int                a;
        int                b;
        int                p;
        int                q;
        int                lo;
        int                hi;
        logic [CHAR_W-1:0] t;
        fresh_q.delete();
        if (op == OP_LOAD) begin
            if (st) pm_len = 0;
            if (pm_len < CAPACITY) begin
                pm_store[pm_len] = ch;
                pm_len++;
            end
            pm_sorted    = 1'b0;
            pm_exhausted = 1'b0;
        end else if (pm_len == 0) begin
            note_status(ST_EMPTY);
        end else if (!pm_sorted) begin
            for (a = 0; a + 1 < pm_len; a++) begin
                for (b = a + 1; b < pm_len; b++) begin
                    if (pm_store[a] > pm_store[b]) begin
                        t           = pm_store[a];
                        pm_store[a] = pm_store[b];
                        pm_store[b] = t;
                    end
                end
            end
            pm_sorted = 1'b1;
            emit_store();
        end else if (pm_exhausted) begin
            note_status(ST_DONE);
        end else begin
            p = pm_len - 1;
            while (p > 0 && pm_store[p-1] >= pm_store[p]) p--;
            if (p == 0) begin
                pm_exhausted = 1'b1;
                note_status(ST_DONE);
            end else begin
                p--;
                q = pm_len - 1;
                while (pm_store[q] <= pm_store[p]) q--;
                t           = pm_store[p];
                pm_store[p] = pm_store[q];
                pm_store[q] = t;
                lo = p + 1;
                hi = pm_len - 1;
                while (lo < hi) begin
                    t            = pm_store[lo];
                    pm_store[lo] = pm_store[hi];
                    pm_store[hi] = t;
                    lo++;
                    hi--;
                end
                emit_store();
            end
        end
    endfunction

    task automatic push_item(input logic op, input logic [CHAR_W-1:0] ch, input logic st,
                             input logic typed, input t_status want);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_bus.valid        <= 1'b1;
        in_bus.operation    <= op;
        in_bus.char_value   <= ch;
        in_bus.start_string <= st;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        predict_item(op, ch, st);
        if (typed) begin
            perm_exp_q.push_back('{position: '0, char_out: '0, last: 1'b1, status: want});
        end else begin
            foreach (fresh_q[k]) perm_exp_q.push_back(fresh_q[k]);
        end
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (perm_exp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_string(input int n, input bit narrow);
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] ch;
        base = CHAR_W'($urandom_range(0, 255));
        for (int k = 0; k < n; k++) begin
            ch = narrow ? base + CHAR_W'($urandom_range(0, 2)) : CHAR_W'($urandom_range(0, 255));
            push_item(OP_LOAD, ch, (k == 0), 1'b0, ST_CHAR);
        end
    endtask

    task automatic ask_next(input int m);
        repeat (m) begin
            push_item(OP_NEXT, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, ST_CHAR);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // receiver: short random stalls, one long hold on request
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_bus.ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD - 1;
            out_bus.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left    = $urandom_range(0, 7);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (perm_exp_q.size() == 0) begin
                mismatches++;
                $display("%0t: extra result, expected none, actual pos %0d char %0d",
                         $time, out_bus.position, out_bus.char_out);
            end else begin
                mon_want = perm_exp_q.pop_front();
                check_field("position", mon_want.position, out_bus.position);
                check_field("char_out", mon_want.char_out, out_bus.char_out);
                check_field("last", mon_want.last, out_bus.last);
                check_field("status", mon_want.status, out_bus.status);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int kind;
        int n;
        int span;
        in_bus.valid        = 1'b0;
        in_bus.operation    = OP_LOAD;
        in_bus.char_value   = '0;
        in_bus.start_string = 1'b0;
        out_bus.ready       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            push_item(dir_tab[r].op, dir_tab[r].ch, dir_tab[r].st, dir_tab[r].typed,
                      dir_tab[r].want);
        end
        drain();

        // fill the block against a held-off receiver, then pause until drained
        long_hold_req = 1'b1;
        load_string(4, 1'b0);
        ask_next(10);
        drain();

        while (items_sent < N_ITEMS) begin
            if (items_sent >= N_ITEMS - QUIET_ITEMS) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    push_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b0, ST_CHAR);
                end
                1: begin
                    load_string($urandom_range(14, 20), 1'($urandom_range(0, 1)));
                    ask_next($urandom_range(1, 3));
                end
                2: begin
                    load_string($urandom_range(2, 4), 1'b1);
                    ask_next($urandom_range(1, 4));
                    push_item(OP_LOAD, CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, ST_CHAR);
                    ask_next($urandom_range(1, 6));
                end
                default: begin
                    n    = $urandom_range(1, 4);
                    span = 1;
                    for (int k = 2; k <= n; k++) span = span * k;
                    load_string(n, 1'($urandom_range(0, 1)));
                    ask_next($urandom_range(1, span + 2));
                end
            endcase
            if (gaps_on && $urandom_range(0, 7) == 0) drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && perm_exp_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
